/* design/running_mean_variance_minmax_unit_macros.svh */
// assertion macros for the running statistics unit
// included by the modules that check their own logic; no other dependencies
`ifndef RUNNING_MEAN_VARIANCE_MINMAX_UNIT_MACROS_SVH
`define RUNNING_MEAN_VARIANCE_MINMAX_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RMVM_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmvm check failed");
// next-cycle implication
`define RMVM_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmvm check failed");
`else
`define RMVM_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define RMVM_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

/* design/rmvm_pkg.sv */
// shared types and constants of the running statistics unit
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package rmvm_pkg;

  // width of the sample counter
  localparam int COUNT_BITS = 32;
  // field widths
  localparam int SAMPLE_W = 32;
  localparam int POS_W    = 32;
  localparam int SUM_W    = 64;
  localparam int HALF_W   = SUM_W / 2;
  // divisor holds count + 1 exactly
  localparam int DIV_W     = COUNT_BITS + 1;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  // datapath operations, one per microcode step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT,
    OP_DIFF,
    OP_DIV_MEAN,
    OP_DIV_WAIT,
    OP_MEAN,
    OP_DEV,
    OP_MUL,
    OP_ACC,
    OP_DIV_VAR,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } ctrl_t;

  // conditions the sequencer branches on
  typedef struct packed {
    logic item;
    logic first;
    logic few;
    logic out_full;
  } status_t;

  // divider request
  typedef struct packed {
    logic start;
    logic half;
  } div_req_t;

endpackage

/* design/rmvm_in_if.sv */
// input channel of the running statistics unit: one sample and clear flag per item
// depends on rmvm_pkg for field widths
`timescale 1ns / 1ps

interface rmvm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rmvm_pkg::SAMPLE_W-1:0] sample;
  logic                                clear;

  modport source (output valid, output sample, output clear, input ready);
  modport sink (input valid, input sample, input clear, output ready);
endinterface

/* design/rmvm_out_if.sv */
// output channel of the running statistics unit: one statistics record per item
// depends on rmvm_pkg for field widths
`timescale 1ns / 1ps

interface rmvm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rmvm_pkg::SAMPLE_W-1:0] mean;
  logic [rmvm_pkg::SUM_W-1:0]           sum_sq_dev;
  logic [rmvm_pkg::SUM_W-1:0]           variance;
  logic                                 variance_valid;
  logic signed [rmvm_pkg::SAMPLE_W-1:0] min_sample;
  logic signed [rmvm_pkg::SAMPLE_W-1:0] max_sample;
  logic [rmvm_pkg::POS_W-1:0]           min_position;
  logic [rmvm_pkg::POS_W-1:0]           max_position;
  logic [rmvm_pkg::POS_W-1:0]           sample_count;
  logic                                 sum_saturated;

  modport source (
    output valid, output mean, output sum_sq_dev, output variance, output variance_valid,
    output min_sample, output max_sample, output min_position, output max_position,
    output sample_count, output sum_saturated, input ready
  );
  modport sink (
    input valid, input mean, input sum_sq_dev, input variance, input variance_valid,
    input min_sample, input max_sample, input min_position, input max_position,
    input sample_count, input sum_saturated, output ready
  );
endinterface

/* design/rmvm_divider.sv */
// shared radix-2 restoring divider, one quotient bit per cycle
// depends on rmvm_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "running_mean_variance_minmax_unit_macros.svh"

module rmvm_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  rmvm_pkg::div_req_t           req,
  input  logic [rmvm_pkg::SUM_W-1:0]   dividend,
  input  logic [rmvm_pkg::DIV_W-1:0]   divisor,
  output logic                         busy,
  output logic [rmvm_pkg::SUM_W-1:0]   quotient
);

  logic [rmvm_pkg::DIV_W-1:0]     rem;
  logic [rmvm_pkg::DIV_W-1:0]     div_q;
  logic [rmvm_pkg::SUM_W-1:0]     quo;
  logic [rmvm_pkg::DIV_CNT_W-1:0] cnt;
  logic [rmvm_pkg::DIV_W:0]       shifted;
  logic [rmvm_pkg::DIV_W:0]       diff;
  logic                           fits;

  // one trial subtraction
  assign shifted = {rem, quo[rmvm_pkg::SUM_W-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign fits    = shifted >= {1'b0, div_q};

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.half ? rmvm_pkg::DIV_CNT_W'(rmvm_pkg::HALF_W)
                       : rmvm_pkg::DIV_CNT_W'(rmvm_pkg::SUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == rmvm_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= '0;
      div_q <= divisor;
      quo   <= req.half ? {dividend[rmvm_pkg::HALF_W-1:0], rmvm_pkg::HALF_W'(0)} : dividend;
    end else if (busy) begin
      rem <= fits ? diff[rmvm_pkg::DIV_W-1:0] : shifted[rmvm_pkg::DIV_W-1:0];
      quo <= {quo[rmvm_pkg::SUM_W-2:0], fits};
    end
  end

  assign quotient = quo;

  `RMVM_ASSERT_NEXT(a_div_start_busy, clk, rst, req.start, busy)
  `RMVM_ASSERT_NEXT(a_div_last_step, clk, rst, busy && !req.start && cnt == rmvm_pkg::DIV_CNT_W'(1), !busy)
  `RMVM_ASSERT_IMPLY(a_div_rem_below, clk, rst, busy, rem < div_q)

endmodule

/* design/rmvm_sequencer.sv */
// microcode sequencer: step counter, control store and conditional jumps
// depends on rmvm_pkg for the operation codes and status struct
`timescale 1ns / 1ps

module rmvm_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  rmvm_pkg::status_t status,
  input  logic              div_busy,
  output rmvm_pkg::ctrl_t   ctrl
);

  localparam int PC_W = 4;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_ITEM,
    COND_FIRST,
    COND_DIV_BUSY,
    COND_FEW,
    COND_OUT_FULL
  } cond_t;

  typedef struct packed {
    rmvm_pkg::op_t   op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // step addresses
  localparam logic [PC_W-1:0] PC_WAIT   = PC_W'(0);
  localparam logic [PC_W-1:0] PC_DIFF   = PC_W'(1);
  localparam logic [PC_W-1:0] PC_DIVM   = PC_W'(2);
  localparam logic [PC_W-1:0] PC_WAITM  = PC_W'(3);
  localparam logic [PC_W-1:0] PC_MEAN   = PC_W'(4);
  localparam logic [PC_W-1:0] PC_DEV    = PC_W'(5);
  localparam logic [PC_W-1:0] PC_MUL    = PC_W'(6);
  localparam logic [PC_W-1:0] PC_ACC    = PC_W'(7);
  localparam logic [PC_W-1:0] PC_DIVV   = PC_W'(8);
  localparam logic [PC_W-1:0] PC_WAITV  = PC_W'(9);
  localparam logic [PC_W-1:0] PC_OUT    = PC_W'(10);
  localparam logic [PC_W-1:0] PC_LOOP   = PC_W'(11);

  // control store
  function automatic uword_t rom(input logic [PC_W-1:0] a);
    uword_t w;
    case (a)
      PC_WAIT:  w = '{rmvm_pkg::OP_WAIT,     COND_NO_ITEM,  PC_WAIT};
      PC_DIFF:  w = '{rmvm_pkg::OP_DIFF,     COND_FIRST,    PC_ACC};
      PC_DIVM:  w = '{rmvm_pkg::OP_DIV_MEAN, COND_NEVER,    PC_WAIT};
      PC_WAITM: w = '{rmvm_pkg::OP_DIV_WAIT, COND_DIV_BUSY, PC_WAITM};
      PC_MEAN:  w = '{rmvm_pkg::OP_MEAN,     COND_NEVER,    PC_WAIT};
      PC_DEV:   w = '{rmvm_pkg::OP_DEV,      COND_NEVER,    PC_WAIT};
      PC_MUL:   w = '{rmvm_pkg::OP_MUL,      COND_NEVER,    PC_WAIT};
      PC_ACC:   w = '{rmvm_pkg::OP_ACC,      COND_NEVER,    PC_WAIT};
      PC_DIVV:  w = '{rmvm_pkg::OP_DIV_VAR,  COND_FEW,      PC_OUT};
      PC_WAITV: w = '{rmvm_pkg::OP_DIV_WAIT, COND_DIV_BUSY, PC_WAITV};
      PC_OUT:   w = '{rmvm_pkg::OP_OUT,      COND_OUT_FULL, PC_OUT};
      PC_LOOP:  w = '{rmvm_pkg::OP_NOP,      COND_ALWAYS,   PC_WAIT};
      default:  w = '{rmvm_pkg::OP_NOP,      COND_ALWAYS,   PC_WAIT};
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          word;
  logic            take;

  assign word = rom(pc);

  // branch condition
  always_comb begin
    case (word.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_ITEM:  take = !status.item;
      COND_FIRST:    take = status.first;
      COND_DIV_BUSY: take = div_busy;
      COND_FEW:      take = status.few;
      COND_OUT_FULL: take = status.out_full;
      default:       take = 1'b1;
    endcase
    pc_next = take ? word.target : pc + 1'b1;
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl.op = word.op;

endmodule

/* design/rmvm_datapath.sv */
// statistics registers, deviation arithmetic, multiplier and output register
// depends on rmvm_pkg, the channel interfaces and the assertion macro header
`timescale 1ns / 1ps
`include "running_mean_variance_minmax_unit_macros.svh"

module rmvm_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  rmvm_pkg::ctrl_t              ctrl,
  rmvm_in_if.sink                      samples,
  rmvm_out_if.source                   stats,
  output rmvm_pkg::status_t            status,
  output rmvm_pkg::div_req_t           div_req,
  output logic [rmvm_pkg::SUM_W-1:0]   div_dividend,
  output logic [rmvm_pkg::DIV_W-1:0]   div_divisor,
  input  logic [rmvm_pkg::SUM_W-1:0]   div_quotient
);

  localparam int SW = rmvm_pkg::SAMPLE_W;
  localparam int CB = rmvm_pkg::COUNT_BITS;

  // clamp a count to the position width
  function automatic logic [rmvm_pkg::POS_W-1:0] sat32(input logic [CB-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (|w[63:32]) ? '1 : w[rmvm_pkg::POS_W-1:0];
  endfunction

  // statistics state
  logic signed [SW-1:0]            run_mean;
  logic [rmvm_pkg::SUM_W-1:0]      run_sum_sq;
  logic signed [SW-1:0]            lowest;
  logic signed [SW-1:0]            highest;
  logic [rmvm_pkg::POS_W-1:0]      lowest_at;
  logic [rmvm_pkg::POS_W-1:0]      highest_at;
  logic [CB-1:0]                   seen;
  logic                            overflowed;

  // per-item working registers
  logic signed [SW-1:0]            x;
  logic                            d_neg;
  logic [SW-1:0]                   ad;
  logic [SW-1:0]                   e_mag;
  logic                            term_en;
  logic [rmvm_pkg::SUM_W-1:0]      term;

  // output register
  logic                            out_valid;
  logic signed [SW-1:0]            o_mean;
  logic [rmvm_pkg::SUM_W-1:0]      o_sum;
  logic [rmvm_pkg::SUM_W-1:0]      o_var;
  logic                            o_var_valid;
  logic signed [SW-1:0]            o_min;
  logic signed [SW-1:0]            o_max;
  logic [rmvm_pkg::POS_W-1:0]      o_min_at;
  logic [rmvm_pkg::POS_W-1:0]      o_max_at;
  logic [rmvm_pkg::POS_W-1:0]      o_count;
  logic                            o_sat;

  logic                            item;
  logic                            first;
  logic                            few;
  logic                            out_full;
  logic                            load;
  logic [SW:0]                     d;
  logic [SW:0]                     d_abs;
  logic [SW:0]                     mk;
  logic [SW:0]                     e;
  logic [SW:0]                     e_abs;
  logic [rmvm_pkg::SUM_W-1:0]      prod;
  logic [rmvm_pkg::SUM_W:0]        sum_ext;
  logic [SW-1:0]                   q;

  // handshake and branch status
  assign samples.ready   = (ctrl.op == rmvm_pkg::OP_WAIT) && !rst;
  assign item            = samples.valid && samples.ready;
  assign first           = (seen == '0);
  assign few             = ((seen >> 1) == '0);
  assign out_full        = out_valid && !stats.ready;
  assign load            = (ctrl.op == rmvm_pkg::OP_OUT) && !out_full;
  assign status.item     = item;
  assign status.first    = first;
  assign status.few      = few;
  assign status.out_full = out_full;

  // deviation from the old mean and its magnitude
  assign d     = {x[SW-1], x} - {run_mean[SW-1], run_mean};
  assign d_abs = d[SW] ? (SW+1)'(0) - d : d;

  // mean step, quotient taken from the low half
  assign q  = div_quotient[SW-1:0];
  assign mk = d_neg ? {run_mean[SW-1], run_mean} - {1'b0, q}
                    : {run_mean[SW-1], run_mean} + {1'b0, q};

  // deviation from the new mean
  assign e     = {x[SW-1], x} - {run_mean[SW-1], run_mean};
  assign e_abs = e[SW] ? (SW+1)'(0) - e : e;

  // product of the two deviation magnitudes
  assign prod    = ad * e_mag;
  assign sum_ext = {1'b0, run_sum_sq} + {1'b0, term};

  // divider requests: mean uses the short run, variance the full one
  always_comb begin
    div_req.start = 1'b0;
    div_req.half  = 1'b0;
    div_dividend  = {rmvm_pkg::HALF_W'(0), ad};
    div_divisor   = {1'b0, seen} + 1'b1;
    case (ctrl.op)
      rmvm_pkg::OP_DIV_MEAN: begin
        div_req.start = 1'b1;
        div_req.half  = 1'b1;
      end
      rmvm_pkg::OP_DIV_VAR: begin
        div_req.start = !few;
        div_dividend  = run_sum_sq;
        div_divisor   = {1'b0, seen} - 1'b1;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // statistics state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mean   <= '0;
      run_sum_sq <= '0;
      lowest     <= {1'b0, {(SW-1){1'b1}}};
      highest    <= {1'b1, {(SW-1){1'b0}}};
      lowest_at  <= '1;
      highest_at <= '1;
      seen       <= '0;
      overflowed <= 1'b0;
    end else begin
      case (ctrl.op)
        rmvm_pkg::OP_WAIT: begin
          if (item && samples.clear) begin
            run_mean   <= '0;
            run_sum_sq <= '0;
            lowest     <= {1'b0, {(SW-1){1'b1}}};
            highest    <= {1'b1, {(SW-1){1'b0}}};
            lowest_at  <= '1;
            highest_at <= '1;
            seen       <= '0;
            overflowed <= 1'b0;
          end
        end
        rmvm_pkg::OP_MEAN: begin
          run_mean <= mk[SW-1:0];
        end
        rmvm_pkg::OP_ACC: begin
          if (first) begin
            run_mean   <= x;
            run_sum_sq <= '0;
          end else if (sum_ext[rmvm_pkg::SUM_W]) begin
            run_sum_sq <= '1;
            overflowed <= 1'b1;
          end else begin
            run_sum_sq <= sum_ext[rmvm_pkg::SUM_W-1:0];
          end
          if (first || x < lowest) begin
            lowest    <= x;
            lowest_at <= sat32(seen);
          end
          if (first || x > highest) begin
            highest    <= x;
            highest_at <= sat32(seen);
          end
          if (seen != '1) begin
            seen <= seen + 1'b1;
          end
        end
        default: begin
          seen <= seen;
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (item) begin
      x <= samples.sample;
    end
    if (ctrl.op == rmvm_pkg::OP_DIFF) begin
      d_neg <= d[SW];
      ad    <= d_abs[SW-1:0];
    end
    if (ctrl.op == rmvm_pkg::OP_DEV) begin
      e_mag   <= e_abs[SW-1:0];
      term_en <= (ad != '0) && (e != '0) && (e[SW] == d_neg);
    end
    if (ctrl.op == rmvm_pkg::OP_MUL) begin
      term <= term_en ? prod : '0;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (stats.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      o_mean      <= run_mean;
      o_sum       <= run_sum_sq;
      o_var       <= few ? '0 : div_quotient;
      o_var_valid <= !few;
      o_min       <= lowest;
      o_max       <= highest;
      o_min_at    <= lowest_at;
      o_max_at    <= highest_at;
      o_count     <= sat32(seen);
      o_sat       <= overflowed;
    end
  end

  assign stats.valid          = out_valid;
  assign stats.mean           = o_mean;
  assign stats.sum_sq_dev     = o_sum;
  assign stats.variance       = o_var;
  assign stats.variance_valid = o_var_valid;
  assign stats.min_sample     = o_min;
  assign stats.max_sample     = o_max;
  assign stats.min_position   = o_min_at;
  assign stats.max_position   = o_max_at;
  assign stats.sample_count   = o_count;
  assign stats.sum_saturated  = o_sat;

  `RMVM_ASSERT_IMPLY(a_sat_holds_ones, clk, rst, overflowed, run_sum_sq == '1)
  `RMVM_ASSERT_IMPLY(a_min_below_max, clk, rst, seen != '0, lowest <= highest)
  `RMVM_ASSERT_NEXT(a_sum_grows, clk, rst, ctrl.op == rmvm_pkg::OP_ACC && seen != '0, run_sum_sq >= $past(run_sum_sq))

endmodule

/* design/running_mean_variance_minmax_unit.sv */
// channel    | dir  | payload
// samples    | in   | sample (Q16.16, signed), clear
// stats      | out  | mean, sum_sq_dev, variance, variance_valid, min/max sample and
//            |      | position, sample_count, sum_saturated
//
// one item in flight: a new sample is taken only once the last item's record is loaded
// into the output register; the pace is set by the shared radix-2 divider (32 steps
// for the mean, 64 for the variance); the first sample after a clear or reset skips
// both divisions; a finished record waits in the output register while the next
// item is taken; a full output register holds the sequencer at its output step
// synchronous active-high reset clears all statistics, no clearing pass
//
// top level of the running mean, variance and min/max unit
// depends on rmvm_pkg, the channel interfaces, sequencer, datapath and divider
`timescale 1ns / 1ps

module running_mean_variance_minmax_unit (
  input logic        clk,
  input logic        rst,
  rmvm_in_if.sink    samples,
  rmvm_out_if.source stats
);

  rmvm_pkg::ctrl_t              ctrl;
  rmvm_pkg::status_t            status;
  rmvm_pkg::div_req_t           div_req;
  logic                         div_busy;
  logic [rmvm_pkg::SUM_W-1:0]   div_dividend;
  logic [rmvm_pkg::DIV_W-1:0]   div_divisor;
  logic [rmvm_pkg::SUM_W-1:0]   div_quotient;

  // microcode control
  rmvm_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .div_busy (div_busy),
    .ctrl     (ctrl)
  );

  // statistics datapath
  rmvm_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .samples      (samples),
    .stats        (stats),
    .status       (status),
    .div_req      (div_req),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_quotient (div_quotient)
  );

  // shared divider
  rmvm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

endmodule
